// ===== rtl/core/dcf_pkg.sv =====
// Package with the opcodes, state and result types shared by the channel fader.
package dcf_pkg;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_FADE_IN  = 2'd1,
    OP_FADE_OUT = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [7:0]  cur_level;
    logic [7:0]  start_level;
    logic [7:0]  target_level;
    logic [23:0] fade_time;
    logic [31:0] last_step_ms;
    logic [31:0] now_ms;
    logic        in_active;
    logic        out_active;
  } fader_state_t;

  typedef struct packed {
    logic       falling;
    logic       rising;
    logic [7:0] level;
  } fader_result_t;

  localparam int unsigned InDataWidth  = 32;
  localparam int unsigned OutDataWidth = 16;

endpackage

// ===== rtl/core/dmx_channel_fader_unit.sv =====
// Top level of the channel fader: state registers and a two-entry output buffer.
//
// The block fades one 8-bit lighting level linearly toward a target.
// The input channel carries the opcode in tuser: a tick counts one
// millisecond and runs one fade update, a fade-in or fade-out command loads
// the target level and duration from tdata and cancels the opposite fade.
// Every accepted input item yields exactly one result item on the output
// channel with the level and the rising and falling flags after that item.
// The update is one pass of logic between the state registers and the
// output register, and the block accepts one item in every cycle while
// input tready is high. A second output register catches one more
// result while the receiver stalls; input tready drops only when both
// output registers are full and resumes as soon as the receiver takes
// an item. Reset clears the level, the fade state, the millisecond
// clock and the valid flags of both output registers.
module dmx_channel_fader_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0: level_arg[7:0], duration_ms[31:8].
  input  logic [31:0] s_axis_tdata_i,
  // Fields from bit 0: opcode[1:0].
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0: level[7:0], rising[8], falling[9], zeros[15:10].
  output logic [15:0] m_axis_tdata_o
);

  dcf_pkg::fader_state_t  state_q, state_d;
  dcf_pkg::fader_result_t result_d, out_q, skid_q;
  logic                   out_valid_q, skid_valid_q;
  logic                   accept, pop;

  assign s_axis_tready_o = !skid_valid_q;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = out_valid_q && m_axis_tready_i;

  dcf_update u_update (
    .state_i       (state_q),
    .opcode_i      (s_axis_tuser_i),
    .level_arg_i   (s_axis_tdata_i[7:0]),
    .duration_ms_i (s_axis_tdata_i[31:8]),
    .state_o       (state_d),
    .result_o      (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || pop) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (accept) begin
      if (!out_valid_q || pop) begin
        out_q <= result_d;
      end else begin
        skid_q <= result_d;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_q};

endmodule

// ===== rtl/core/dcf_update.sv =====
// Next-state logic of the fader: applies one command or one millisecond tick.
module dcf_update (
  input  dcf_pkg::fader_state_t  state_i,
  input  logic [1:0]             opcode_i,
  input  logic [7:0]             level_arg_i,
  input  logic [23:0]            duration_ms_i,
  output dcf_pkg::fader_state_t  state_o,
  output dcf_pkg::fader_result_t result_o
);

  logic [31:0] now_inc;
  logic [31:0] elapsed;
  logic [7:0]  span;
  logic [39:0] product;
  logic        step_due;

  assign now_inc = state_i.now_ms + 32'd1;
  assign elapsed = now_inc - state_i.last_step_ms;
  assign span    = (state_i.start_level > state_i.target_level) ?
                   (state_i.start_level - state_i.target_level) :
                   (state_i.target_level - state_i.start_level);
  assign product  = 40'(elapsed) * 40'(span);
  assign step_due = product > {16'd0, state_i.fade_time};

  always_comb begin
    state_o = state_i;
    case (opcode_i)
      dcf_pkg::OP_TICK: begin
        state_o.now_ms = now_inc;
        if (state_i.in_active) begin
          if (state_i.cur_level >= state_i.target_level) begin
            state_o.cur_level   = state_i.target_level;
            state_o.start_level = state_i.target_level;
            state_o.in_active   = 1'b0;
          end else if (step_due) begin
            state_o.last_step_ms = now_inc;
            state_o.cur_level    = state_i.cur_level + 8'd1;
          end
        end else if (state_i.out_active) begin
          if (state_i.cur_level <= state_i.target_level) begin
            state_o.cur_level   = state_i.target_level;
            state_o.start_level = state_i.target_level;
            state_o.out_active  = 1'b0;
          end else if (step_due) begin
            state_o.last_step_ms = now_inc;
            state_o.cur_level    = state_i.cur_level - 8'd1;
          end
        end
      end
      dcf_pkg::OP_FADE_IN, dcf_pkg::OP_FADE_OUT: begin
        state_o.target_level = level_arg_i;
        state_o.fade_time    = duration_ms_i;
        state_o.last_step_ms = 32'd0;
        state_o.in_active    = (opcode_i == dcf_pkg::OP_FADE_IN);
        state_o.out_active   = (opcode_i == dcf_pkg::OP_FADE_OUT);
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

  assign result_o.level   = state_o.cur_level;
  assign result_o.rising  = state_o.in_active;
  assign result_o.falling = state_o.out_active;

endmodule

// ===== verif/dcf_fade_checker.sv =====
// Checker for the channel fader: predicts every result item and compares it field by field.
module dcf_fade_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [dcf_pkg::InDataWidth-1:0]  in_data_i,
  input  logic [1:0]                       in_user_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [dcf_pkg::OutDataWidth-1:0] out_data_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               items_o,
  output int                               results_o,
  output int                               rises_o,
  output int                               falls_o,
  output int                               arrivals_o
);
  timeunit 1ns;
  timeprecision 1ps;

  dcf_pkg::fader_state_t  fade_q;
  dcf_pkg::fader_result_t level_q[$];
  int fails = 0;
  int items = 0;
  int results = 0;
  int rises = 0;
  int falls = 0;
  int arrivals = 0;

  assign fail_count_o = fails;
  assign items_o      = items;
  assign results_o    = results;
  assign rises_o      = rises;
  assign falls_o      = falls;
  assign arrivals_o   = arrivals;

  task automatic report_mismatch(input string msg);
    fails++;
    $display("[%0t] fader mismatch: %s", $time, msg);
  endtask

  function automatic logic step_ready(input dcf_pkg::fader_state_t s);
    logic [31:0] elapsed;
    logic [7:0]  span;
    logic [39:0] prod;
    elapsed = s.now_ms - s.last_step_ms;
    span = (s.start_level > s.target_level) ? s.start_level - s.target_level
                                            : s.target_level - s.start_level;
    prod = 40'(elapsed) * 40'(span);
    return prod > {16'd0, s.fade_time};
  endfunction

  task automatic advance_fade(input dcf_pkg::opcode_e op, input logic [7:0] lvl,
                              input logic [23:0] dur);
    case (op)
      dcf_pkg::OP_TICK: begin
        fade_q.now_ms = fade_q.now_ms + 32'd1;
        if (fade_q.in_active) begin
          if (fade_q.cur_level >= fade_q.target_level) begin
            fade_q.cur_level   = fade_q.target_level;
            fade_q.start_level = fade_q.target_level;
            fade_q.in_active   = 1'b0;
            arrivals++;
          end else if (step_ready(fade_q)) begin
            fade_q.last_step_ms = fade_q.now_ms;
            fade_q.cur_level    = fade_q.cur_level + 8'd1;
            rises++;
          end
        end
        if (fade_q.out_active) begin
          if (fade_q.cur_level <= fade_q.target_level) begin
            fade_q.cur_level   = fade_q.target_level;
            fade_q.start_level = fade_q.target_level;
            fade_q.out_active  = 1'b0;
            arrivals++;
          end else if (step_ready(fade_q)) begin
            fade_q.last_step_ms = fade_q.now_ms;
            fade_q.cur_level    = fade_q.cur_level - 8'd1;
            falls++;
          end
        end
      end
      dcf_pkg::OP_FADE_IN, dcf_pkg::OP_FADE_OUT: begin
        fade_q.target_level = lvl;
        fade_q.fade_time    = dur;
        fade_q.last_step_ms = '0;
        fade_q.in_active    = (op == dcf_pkg::OP_FADE_IN);
        fade_q.out_active   = (op == dcf_pkg::OP_FADE_OUT);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    dcf_pkg::fader_result_t got;
    dcf_pkg::fader_result_t want;
    if (!rst_ni) begin
      fade_q = '0;
      level_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = out_data_i[9:0];
        results++;
        if (level_q.size() == 0) begin
          report_mismatch($sformatf("result 0x%04h with nothing expected", out_data_i));
        end else begin
          want = level_q.pop_front();
          if (got.level != want.level)
            report_mismatch($sformatf("level got %0d, expected %0d", got.level, want.level));
          if (got.rising != want.rising)
            report_mismatch($sformatf("rising got %0b, expected %0b",
                                      got.rising, want.rising));
          if (got.falling != want.falling)
            report_mismatch($sformatf("falling got %0b, expected %0b",
                                      got.falling, want.falling));
          if (out_data_i[dcf_pkg::OutDataWidth-1:10] != '0)
            report_mismatch($sformatf("padding bits got 0x%0h",
                                      out_data_i[dcf_pkg::OutDataWidth-1:10]));
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_fade(dcf_pkg::opcode_e'(in_user_i), in_data_i[7:0], in_data_i[31:8]);
        items++;
        want.level   = fade_q.cur_level;
        want.rising  = fade_q.in_active;
        want.falling = fade_q.out_active;
        level_q.push_back(want);
      end
      pending_o <= level_q.size();
    end
  end

endmodule

// ===== verif/tb_dmx_channel_fader_unit.sv =====
// Testbench top for the channel fader: clock, reset, stimulus and the final verdict.
module tb_dmx_channel_fader_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TotalItems = 1750;
  localparam logic [1:0] OpUnused = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             s_valid = 1'b0;
  logic [dcf_pkg::InDataWidth-1:0]  s_data = '0;
  logic [1:0]                       s_user = '0;
  logic                             m_ready = 1'b0;
  logic                             s_ready;
  logic                             m_valid;
  logic [dcf_pkg::OutDataWidth-1:0] m_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int sent = 0;
  int fail_count, pending, items, results, rises, falls, arrivals;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dmx_channel_fader_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  dcf_fade_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_data_i    (s_data),
    .in_user_i    (s_user),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .items_o      (items),
    .results_o    (results),
    .rises_o      (rises),
    .falls_o      (falls),
    .arrivals_o   (arrivals)
  );

  always @(posedge clk) begin
    m_ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] lvl,
                           input logic [23:0] dur);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {dur, lvl};
    s_user  <= op;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sent++;
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_item(dcf_pkg::OP_TICK, 8'($urandom), 24'($urandom));
  endtask

  initial begin : stimulus
    int          pick;
    int          sel;
    int          n;
    logic [1:0]  op;
    logic [23:0] dur;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: ignored fields, unused opcode, zero distance, snaps both ways,
    // the longest duration and a fade cancelled by the opposite command.
    send_item(dcf_pkg::OP_TICK, 8'hFF, 24'hFFFFFF);
    send_item(OpUnused, 8'hFF, 24'hFFFFFF);
    send_item(dcf_pkg::OP_FADE_IN, 8'h00, 24'h000000);
    run_ticks(1);
    send_item(dcf_pkg::OP_FADE_IN, 8'h03, 24'h000000);
    run_ticks(4);
    send_item(dcf_pkg::OP_FADE_OUT, 8'h00, 24'h000002);
    run_ticks(4);
    send_item(dcf_pkg::OP_FADE_IN, 8'hFF, 24'h000000);
    run_ticks(2);
    send_item(dcf_pkg::OP_FADE_OUT, 8'hC0, 24'h000000);
    run_ticks(1);
    send_item(dcf_pkg::OP_FADE_IN, 8'h10, 24'h000000);
    run_ticks(1);
    send_item(dcf_pkg::OP_FADE_IN, 8'hFF, 24'hFFFFFF);
    run_ticks(1);
    send_item(OpUnused, 8'h00, 24'h000000);
    send_item(dcf_pkg::OP_FADE_OUT, 8'h00, 24'h000000);
    run_ticks(1);

    while (sent < TotalItems) begin
      case ((sent * 4) / TotalItems)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 48; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 48; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        op  = $urandom_range(0, 1) ? dcf_pkg::OP_FADE_IN : dcf_pkg::OP_FADE_OUT;
        sel = $urandom_range(0, 99);
        if (sel < 50)
          dur = 24'($urandom_range(0, 64));
        else if (sel < 85)
          dur = 24'($urandom_range(0, 3000));
        else
          dur = 24'($urandom);
        send_item(op, 8'($urandom), dur);
        n = $urandom_range(1, 80);
        repeat (n) begin
          if ($urandom_range(0, 99) < 4)
            send_item(OpUnused, 8'($urandom), 24'($urandom));
          else
            send_item(dcf_pkg::OP_TICK, 8'($urandom), 24'($urandom));
        end
      end else begin
        send_item(2'($urandom_range(0, 3)), 8'($urandom), 24'($urandom));
      end
    end
    s_valid <= 1'b0;
    stall_pct = 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d items and %0d result items over four idle and stall mixes.",
             items, results);
    $display("The level rose %0d times and fell %0d times; %0d fades reached their target.",
             rises, falls, arrivals);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/dcf_pkg.sv
rtl/core/dcf_update.sv
rtl/core/dmx_channel_fader_unit.sv
verif/dcf_fade_checker.sv
verif/tb_dmx_channel_fader_unit.sv
